// ----- rtl/core/lfx_pkg.sv -----
// Shared constants, opcodes and memory request types for the link frame
// exchange engine. No dependencies; used by lfx_ctrl and the top level.
package lfx_pkg;

  // Frame geometry
  localparam int FRAME_WORDS = 10;
  localparam int PLAYERS     = 2;
  localparam int IDX_MAX     = FRAME_WORDS + 1;        // idle / saturated index
  localparam int IDX_W       = $clog2(IDX_MAX + 1);    // send index width
  localparam int RIDX_W      = IDX_W + 1;              // signed receive index width

  // Payload widths
  localparam int HALF_W  = 16;
  localparam int SLOT_W  = 4;
  localparam int ROW_W   = 2 * HALF_W;                 // both received halfwords

  // Memories: two banks of FRAME_WORDS entries each
  localparam int SEND_DEPTH = 2 * FRAME_WORDS;
  localparam int SEND_AW    = $clog2(SEND_DEPTH);
  localparam int RECV_DEPTH = 2 * FRAME_WORDS;
  localparam int RECV_AW    = $clog2(RECV_DEPTH);

  localparam logic [HALF_W-1:0] SYNC_WORD = 16'hFEFE;

  typedef enum logic [1:0] {
    OP_EVENT = 2'd0,
    OP_LOAD  = 2'd1,
    OP_SWAP  = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  // Single-port memory requests
  typedef struct packed {
    logic               en;
    logic               we;
    logic [SEND_AW-1:0] addr;
    logic [HALF_W-1:0]  wdata;
  } send_req_t;

  typedef struct packed {
    logic               en;
    logic               we;
    logic [RECV_AW-1:0] addr;
    logic [ROW_W-1:0]   wdata;
  } recv_req_t;

endpackage

// ----- rtl/core/lfx_ram.sv -----
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module lfx_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 20
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One access per cycle; read data holds until the next read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ----- rtl/core/lfx_ctrl.sv -----
// Control for the link frame exchange engine: indices, banks, request
// sequencing and the result register. Depends on lfx_pkg; drives two lfx_ram.
module lfx_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_timed_mode,
  // request channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_op,
  input  logic [lfx_pkg::HALF_W-1:0]  in_recv_half0,
  input  logic [lfx_pkg::HALF_W-1:0]  in_recv_half1,
  input  logic                        in_role_bit,
  input  logic [lfx_pkg::SLOT_W-1:0]  in_slot,
  input  logic                        in_player,
  input  logic [lfx_pkg::HALF_W-1:0]  in_load_data,
  // memories
  output lfx_pkg::send_req_t          send_req,
  input  logic [lfx_pkg::HALF_W-1:0]  send_rdata,
  output lfx_pkg::recv_req_t          recv_req,
  input  logic [lfx_pkg::ROW_W-1:0]   recv_rdata,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_send_valid,
  output logic [lfx_pkg::HALF_W-1:0]  out_send_word,
  output logic                        out_timer_stop,
  output logic                        out_restart_transfer,
  output logic                        out_sync_seen,
  output logic                        out_frame_done,
  output logic [lfx_pkg::HALF_W-1:0]  out_read_data,
  output logic                        out_role_out
);

  localparam int IDX_W  = lfx_pkg::IDX_W;
  localparam int RIDX_W = lfx_pkg::RIDX_W;
  localparam int SAW    = lfx_pkg::SEND_AW;
  localparam int RAW    = lfx_pkg::RECV_AW;

  localparam logic [IDX_W-1:0] SIDX_FW   = IDX_W'(lfx_pkg::FRAME_WORDS);
  localparam logic [IDX_W-1:0] SIDX_MAX  = IDX_W'(lfx_pkg::IDX_MAX);
  localparam logic [IDX_W-1:0] SIDX_ONE  = IDX_W'(1);
  localparam logic signed [RIDX_W-1:0] RIDX_NEG1 = '1;
  localparam logic signed [RIDX_W-1:0] RIDX_ZERO = '0;
  localparam logic signed [RIDX_W-1:0] RIDX_ONE  = RIDX_W'(1);
  localparam logic signed [RIDX_W-1:0] RIDX_LAST = RIDX_W'(lfx_pkg::FRAME_WORDS - 1);
  localparam logic signed [RIDX_W-1:0] RIDX_FW   = RIDX_W'(lfx_pkg::FRAME_WORDS);
  localparam logic signed [RIDX_W-1:0] RIDX_MAX  = RIDX_W'(lfx_pkg::IDX_MAX);
  localparam logic [SAW-1:0] SEND_BASE1 = SAW'(lfx_pkg::FRAME_WORDS);
  localparam logic [RAW-1:0] RECV_BASE1 = RAW'(lfx_pkg::FRAME_WORDS);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RESP = 2'b10
  } state_t;

  // Flags of the request in flight, waiting on read data
  typedef struct packed {
    logic send_valid;
    logic timer_stop;
    logic restart;
    logic sync;
    logic done;
    logic read_en;
    logic player;
  } res_t;

  state_t                    state_r, state_nxt;
  logic                      timed_r;
  logic                      send_bank_r, send_bank_nxt;
  logic                      recv_bank_r, recv_bank_nxt;
  logic [IDX_W-1:0]          send_index_r, send_index_nxt;
  logic signed [RIDX_W-1:0]  recv_index_r, recv_index_nxt;
  logic                      swap_pending_r, swap_pending_nxt;
  logic                      role_r, role_nxt;
  res_t                      res_r, res_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic                      o_send_valid_r, o_timer_r, o_restart_r, o_sync_r;
  logic                      o_done_r, o_role_r;
  logic [lfx_pkg::HALF_W-1:0] o_send_word_r, o_read_data_r;

  logic                      acc;
  logic                      is_event, is_load, is_swap, is_read;
  logic                      slot_ok, player_ok;
  logic                      sync, swap_now;
  logic                      send_bank_eff, recv_bank_eff;
  logic [IDX_W-1:0]          sidx_eff, sidx_inc;
  logic signed [RIDX_W-1:0]  ridx_eff, ridx_inc;
  logic                      send_hit, recv_store_hit;
  logic [SAW-1:0]            send_ev_addr, send_ld_addr;
  logic [RAW-1:0]            recv_ev_addr, recv_rd_addr;
  logic                      load_out;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign acc       = in_valid && in_ready;

  // Decode
  always_comb begin
    is_event = 1'b0;
    is_load  = 1'b0;
    is_swap  = 1'b0;
    is_read  = 1'b0;
    unique case (in_op)
      lfx_pkg::OP_EVENT: is_event = 1'b1;
      lfx_pkg::OP_LOAD:  is_load  = 1'b1;
      lfx_pkg::OP_SWAP:  is_swap  = 1'b1;
      lfx_pkg::OP_READ:  is_read  = 1'b1;
      default:           is_event = 1'b0;
    endcase
  end

  assign slot_ok   = (32'(in_slot) < 32'(lfx_pkg::FRAME_WORDS));
  assign player_ok = (32'(in_player) < 32'(lfx_pkg::PLAYERS));

  // Sync handling ahead of the send / receive step
  assign sync          = is_event && (in_recv_half0 == lfx_pkg::SYNC_WORD)
                         && (recv_index_r > RIDX_LAST);
  assign swap_now      = sync && swap_pending_r;
  assign send_bank_eff = send_bank_r ^ swap_now;
  assign recv_bank_eff = recv_bank_r ^ sync;
  assign sidx_eff      = swap_now ? '0 : send_index_r;
  assign ridx_eff      = sync ? RIDX_NEG1 : recv_index_r;

  // Index stepping, saturating at FRAME_WORDS + 1
  assign send_hit       = (sidx_eff < SIDX_FW);
  assign sidx_inc       = (sidx_eff <= SIDX_FW) ? sidx_eff + SIDX_ONE : sidx_eff;
  assign recv_store_hit = (ridx_eff >= RIDX_ZERO) && (ridx_eff < RIDX_FW);
  assign ridx_inc       = (ridx_eff <= RIDX_FW) ? ridx_eff + RIDX_ONE : ridx_eff;

  // Bank base plus word offset
  assign send_ev_addr = (send_bank_eff ? SEND_BASE1 : '0) + SAW'(sidx_eff);
  assign send_ld_addr = (send_bank_r ? '0 : SEND_BASE1) + SAW'(in_slot);
  assign recv_ev_addr = (recv_bank_eff ? RECV_BASE1 : '0) + RAW'($unsigned(ridx_eff));
  assign recv_rd_addr = (recv_bank_r ? '0 : RECV_BASE1) + RAW'(in_slot);

  // Memory requests, issued only at the accept edge
  always_comb begin
    send_req.en    = acc && ((is_event && send_hit) || (is_load && slot_ok));
    send_req.we    = is_load;
    send_req.addr  = is_load ? send_ld_addr : send_ev_addr;
    send_req.wdata = in_load_data;
    recv_req.en    = acc && ((is_event && recv_store_hit) ||
                             (is_read && slot_ok && player_ok));
    recv_req.we    = is_event;
    recv_req.addr  = is_event ? recv_ev_addr : recv_rd_addr;
    recv_req.wdata = {in_recv_half1, in_recv_half0};
  end

  // Engine state update on accept
  always_comb begin
    send_bank_nxt    = send_bank_r;
    recv_bank_nxt    = recv_bank_r;
    send_index_nxt   = send_index_r;
    recv_index_nxt   = recv_index_r;
    swap_pending_nxt = swap_pending_r;
    role_nxt         = role_r;
    res_nxt          = res_r;
    if (acc) begin
      res_nxt.send_valid = is_event && send_hit;
      res_nxt.timer_stop = is_event && timed_r;
      res_nxt.restart    = is_event && timed_r && (sidx_inc <= SIDX_FW);
      res_nxt.sync       = sync;
      res_nxt.done       = is_event && (ridx_eff == RIDX_LAST);
      res_nxt.read_en    = is_read && slot_ok && player_ok;
      res_nxt.player     = in_player;
      if (is_event) begin
        role_nxt       = in_role_bit;
        send_bank_nxt  = send_bank_eff;
        recv_bank_nxt  = recv_bank_eff;
        send_index_nxt = sidx_inc;
        recv_index_nxt = ridx_inc;
        if (swap_now) begin
          swap_pending_nxt = 1'b0;
        end
      end
      if (is_swap) begin
        swap_pending_nxt = 1'b1;
      end
    end
  end

  // Sequencer: accept, then wait in ST_RESP for read data and hand off once the result register is free
  assign load_out = (state_r == ST_RESP) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (acc)      state_nxt = ST_RESP;
      ST_RESP: if (load_out) state_nxt = ST_IDLE;
      default:               state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      timed_r        <= 1'b0;
      send_bank_r    <= 1'b0;
      recv_bank_r    <= 1'b0;
      send_index_r   <= SIDX_MAX;
      recv_index_r   <= RIDX_MAX;
      swap_pending_r <= 1'b0;
      role_r         <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        timed_r <= cfg_timed_mode;
      end
      send_bank_r    <= send_bank_nxt;
      recv_bank_r    <= recv_bank_nxt;
      send_index_r   <= send_index_nxt;
      recv_index_r   <= recv_index_nxt;
      swap_pending_r <= swap_pending_nxt;
      role_r         <= role_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (load_out) begin
      o_send_valid_r <= res_r.send_valid;
      o_send_word_r  <= res_r.send_valid ? send_rdata : '0;
      o_timer_r      <= res_r.timer_stop;
      o_restart_r    <= res_r.restart;
      o_sync_r       <= res_r.sync;
      o_done_r       <= res_r.done;
      o_read_data_r  <= !res_r.read_en ? '0 :
                        (res_r.player ? recv_rdata[lfx_pkg::ROW_W-1:lfx_pkg::HALF_W]
                                      : recv_rdata[lfx_pkg::HALF_W-1:0]);
      o_role_r       <= role_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_send_valid       = o_send_valid_r;
  assign out_send_word        = o_send_word_r;
  assign out_timer_stop       = o_timer_r;
  assign out_restart_transfer = o_restart_r;
  assign out_sync_seen        = o_sync_r;
  assign out_frame_done       = o_done_r;
  assign out_read_data        = o_read_data_r;
  assign out_role_out         = o_role_r;

  // Checks
  a_acc_to_resp: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> (state_r == ST_RESP))
    else $error("accepted request did not move to response state");

  a_send_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    send_index_r <= SIDX_MAX)
    else $error("send index beyond saturation");

  a_recv_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (recv_index_r >= RIDX_NEG1) && (recv_index_r <= RIDX_MAX))
    else $error("receive index out of range");

  a_mem_only_on_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (send_req.en || recv_req.en) |-> acc)
    else $error("memory access outside accept");

  a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_RESP))
    else $error("result loaded outside response state");

  a_sync_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESP) |-> !(res_r.sync && res_r.done))
    else $error("sync and frame completion on one event");

endmodule

// ----- rtl/core/link_frame_exchange_engine.sv -----
// Link frame exchange engine: one request accepted at a time, result registered
// (accept edge issues the memory access and enters ST_RESP; the result register
// is loaded from ST_RESP once it is free, so out_ready can stall it). No new
// request is accepted until the last result is loaded into the result register.
// Synchronous active-low reset clears indices to idle, banks and flags;
// memory contents are undefined until written.
module link_frame_exchange_engine (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_timed_mode,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_op,
  input  logic [lfx_pkg::HALF_W-1:0]  in_recv_half0,
  input  logic [lfx_pkg::HALF_W-1:0]  in_recv_half1,
  input  logic                        in_role_bit,
  input  logic [lfx_pkg::SLOT_W-1:0]  in_slot,
  input  logic                        in_player,
  input  logic [lfx_pkg::HALF_W-1:0]  in_load_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_send_valid,
  output logic [lfx_pkg::HALF_W-1:0]  out_send_word,
  output logic                        out_timer_stop,
  output logic                        out_restart_transfer,
  output logic                        out_sync_seen,
  output logic                        out_frame_done,
  output logic [lfx_pkg::HALF_W-1:0]  out_read_data,
  output logic                        out_role_out
);

  lfx_pkg::send_req_t         send_req;
  lfx_pkg::recv_req_t         recv_req;
  logic [lfx_pkg::HALF_W-1:0] send_rdata;
  logic [lfx_pkg::ROW_W-1:0]  recv_rdata;

  // Staging / active send banks
  lfx_ram #(
    .WIDTH (lfx_pkg::HALF_W),
    .DEPTH (lfx_pkg::SEND_DEPTH)
  ) u_send_ram (
    .clk   (clk),
    .en    (send_req.en),
    .we    (send_req.we),
    .addr  (send_req.addr),
    .wdata (send_req.wdata),
    .rdata (send_rdata)
  );

  // Filling / completed receive banks, both players per row
  lfx_ram #(
    .WIDTH (lfx_pkg::ROW_W),
    .DEPTH (lfx_pkg::RECV_DEPTH)
  ) u_recv_ram (
    .clk   (clk),
    .en    (recv_req.en),
    .we    (recv_req.we),
    .addr  (recv_req.addr),
    .wdata (recv_req.wdata),
    .rdata (recv_rdata)
  );

  lfx_ctrl u_ctrl (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_timed_mode       (cfg_timed_mode),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_op                (in_op),
    .in_recv_half0        (in_recv_half0),
    .in_recv_half1        (in_recv_half1),
    .in_role_bit          (in_role_bit),
    .in_slot              (in_slot),
    .in_player            (in_player),
    .in_load_data         (in_load_data),
    .send_req             (send_req),
    .send_rdata           (send_rdata),
    .recv_req             (recv_req),
    .recv_rdata           (recv_rdata),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_send_valid       (out_send_valid),
    .out_send_word        (out_send_word),
    .out_timer_stop       (out_timer_stop),
    .out_restart_transfer (out_restart_transfer),
    .out_sync_seen        (out_sync_seen),
    .out_frame_done       (out_frame_done),
    .out_read_data        (out_read_data),
    .out_role_out         (out_role_out)
  );

endmodule
